[hw/rtl/rrp_pkg.sv]
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types and constants of the request parser.
// ----------------------------------------------------------------------------
package rrp_pkg;

  localparam int unsigned ArgLimitDefault = 1024;
  localparam int unsigned HwArgCap        = 1024;

  localparam logic [10:0] MaxArgsReset   = 11'd64;
  localparam logic [20:0] MaxArgLenReset = 21'd65536;
  localparam logic [7:0]  DelimReset     = 8'd32;

  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;

  // error field value on events that are not errors
  localparam logic [2:0] ErrNone = 3'd0;

  typedef enum logic [1:0] {
    CFG_MAX_ARGS    = 2'd0,
    CFG_MAX_ARG_LEN = 2'd1,
    CFG_DELIM       = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CNT    = 4'd1,
    PH_CNT_LF = 4'd2,
    PH_DOL    = 4'd3,
    PH_LEN    = 4'd4,
    PH_LEN_LF = 4'd5,
    PH_DATA   = 4'd6,
    PH_DCR    = 4'd7,
    PH_DLF    = 4'd8,
    PH_INL    = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    K_FRAME   = 3'd0,
    K_DATA    = 3'd1,
    K_ARG_END = 3'd2,
    K_CMD_END = 3'd3,
    K_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    E_BAD_COUNT = 3'd0,
    E_BAD_LEN   = 3'd1,
    E_BAD_TERM  = 3'd2,
    E_LIMIT     = 3'd3,
    E_EMPTY_INL = 3'd4
  } err_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_digit;
    logic       is_cr;
    logic       is_lf;
    logic       is_star;
    logic       is_dollar;
    logic       is_delim;
  } item_t;

endpackage

[hw/rtl/rrp_front.sv]
// ----------------------------------------------------------------------------
// rrp_front
// Accepts request bytes, classifies them and holds them in a 2-entry queue.
// ----------------------------------------------------------------------------
module rrp_front import rrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic [7:0] delim,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t       mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       cls;
  logic        push;

  always_comb begin
    cls.data      = in_byte;
    cls.is_digit  = (in_byte >= ChZero) && (in_byte <= ChNine);
    cls.is_cr     = in_byte == ChCr;
    cls.is_lf     = in_byte == ChLf;
    cls.is_star   = in_byte == ChStar;
    cls.is_dollar = in_byte == ChDollar;
    cls.is_delim  = in_byte == delim;
  end

  assign in_ready = cnt_r != 2'd2;
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != 2'd0;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/rrp_back.sv]
// ----------------------------------------------------------------------------
// rrp_back
// Parser state machine; one classified byte per cycle into an output register, unless out_ready holds it.
// ----------------------------------------------------------------------------
module rrp_back import rrp_pkg::*; #(
  parameter int unsigned ARG_LIMIT = ArgLimitDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [10:0] max_args,
  input  logic [20:0] max_arg_len,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [24:0] out_data
);

  localparam int unsigned CapI = (ARG_LIMIT < HwArgCap) ? ARG_LIMIT : HwArgCap;
  localparam logic [10:0] Cap  = 11'(CapI);

  phase_t      phase_r, phase_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [10:0] args_r, args_nxt;
  logic [20:0] bytes_r, bytes_nxt;
  logic [9:0]  cur_r, cur_nxt;
  logic        has_r, has_nxt;
  logic        fe_r, fe_nxt;
  logic        clr;

  logic        ov_r;
  logic [24:0] od_r;

  kind_t       ev_kind;
  logic [2:0]  ev_err;
  logic [7:0]  ev_data;
  logic        ev_inl;

  logic [10:0] lim;
  logic [24:0] acc10;
  logic [20:0] num_lim;
  logic        dig_over;
  logic        inl_act;
  logic [21:0] acc1;
  logic        inl_lim_fail, inl_len_fail, inl_lf_fail, num_bad;
  logic [20:0] bytes_dec;
  logic [10:0] args_dec;

  assign q_pop = q_valid && (!ov_r || out_ready);

  assign lim          = (max_args < Cap) ? max_args : Cap;
  assign acc10        = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                        + {21'd0, q_item.data[3:0]};
  assign num_lim      = (phase_r == PH_CNT) ? {10'd0, lim} : max_arg_len;
  assign dig_over     = acc10 > {4'd0, num_lim};
  assign inl_act      = (phase_r == PH_INL) || (phase_r == PH_IDLE && !q_item.is_star);
  assign acc1         = {1'b0, acc_r} + 22'd1;
  assign inl_lim_fail = !has_r && ({1'b0, cur_r} >= lim);
  assign inl_len_fail = acc1 > {1'b0, max_arg_len};
  assign inl_lf_fail  = fe_r || (cur_r == 10'd0 && !has_r);
  assign num_bad      = !has_r || acc_r == 21'd0;
  assign bytes_dec    = (bytes_r != 21'd0) ? bytes_r - 21'd1 : bytes_r;
  assign args_dec     = (args_r != 11'd0) ? args_r - 11'd1 : args_r;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    args_nxt  = args_r;
    bytes_nxt = bytes_r;
    cur_nxt   = cur_r;
    has_nxt   = has_r;
    fe_nxt    = fe_r;
    clr       = 1'b0;
    if (inl_act) begin
      phase_nxt = PH_INL;
      if (q_item.is_lf) begin
        clr = 1'b1;
      end else if (q_item.is_cr) begin
        phase_nxt = PH_INL;
      end else if (q_item.is_delim) begin
        if (has_r) begin
          cur_nxt = cur_r + 10'd1;
          has_nxt = 1'b0;
          acc_nxt = '0;
        end else if (cur_r == 10'd0) begin
          fe_nxt = 1'b1;
        end
      end else if (inl_lim_fail || inl_len_fail) begin
        clr = 1'b1;
      end else begin
        acc_nxt = acc1[20:0];
        has_nxt = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: phase_nxt = PH_CNT;
        PH_CNT, PH_LEN: begin
          if (q_item.is_digit) begin
            if (dig_over) begin
              clr = 1'b1;
            end else begin
              acc_nxt = acc10[20:0];
              has_nxt = 1'b1;
            end
          end else if (q_item.is_cr && !num_bad) begin
            if (phase_r == PH_CNT) phase_nxt = PH_CNT_LF;
            else phase_nxt = PH_LEN_LF;
          end else begin
            clr = 1'b1;
          end
        end
        PH_CNT_LF: begin
          if (!q_item.is_lf) begin
            clr = 1'b1;
          end else begin
            args_nxt  = acc_r[10:0];
            acc_nxt   = '0;
            has_nxt   = 1'b0;
            cur_nxt   = '0;
            phase_nxt = PH_DOL;
          end
        end
        PH_DOL: begin
          if (!q_item.is_dollar) begin
            clr = 1'b1;
          end else begin
            acc_nxt   = '0;
            has_nxt   = 1'b0;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN_LF: begin
          if (!q_item.is_lf) begin
            clr = 1'b1;
          end else begin
            bytes_nxt = acc_r;
            acc_nxt   = '0;
            has_nxt   = 1'b0;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          bytes_nxt = bytes_dec;
          if (bytes_dec == 21'd0) phase_nxt = PH_DCR;
        end
        PH_DCR: begin
          if (!q_item.is_cr) clr = 1'b1;
          else phase_nxt = PH_DLF;
        end
        PH_DLF: begin
          if (!q_item.is_lf || args_dec == 11'd0) begin
            clr = 1'b1;
          end else begin
            args_nxt  = args_dec;
            cur_nxt   = cur_r + 10'd1;
            phase_nxt = PH_DOL;
          end
        end
        default: clr = 1'b1;
      endcase
    end
    if (clr) begin
      phase_nxt = PH_IDLE;
      acc_nxt   = '0;
      args_nxt  = '0;
      bytes_nxt = '0;
      cur_nxt   = '0;
      has_nxt   = 1'b0;
      fe_nxt    = 1'b0;
    end
  end

  // event fields
  always_comb begin
    ev_kind = K_FRAME;
    ev_err  = ErrNone;
    ev_data = '0;
    ev_inl  = inl_act;
    if (inl_act) begin
      if (q_item.is_lf) begin
        if (inl_lf_fail) begin
          ev_kind = K_ERROR;
          ev_err  = E_EMPTY_INL;
        end else begin
          ev_kind = K_CMD_END;
        end
      end else if (q_item.is_cr) begin
        ev_kind = K_FRAME;
      end else if (q_item.is_delim) begin
        if (has_r) ev_kind = K_ARG_END;
      end else if (inl_lim_fail || inl_len_fail) begin
        ev_kind = K_ERROR;
        ev_err  = E_LIMIT;
      end else begin
        ev_kind = K_DATA;
        ev_data = q_item.data;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: ev_kind = K_FRAME;
        PH_CNT, PH_LEN: begin
          if (q_item.is_digit) begin
            if (dig_over) begin
              ev_kind = K_ERROR;
              ev_err  = E_LIMIT;
            end
          end else if (q_item.is_cr) begin
            if (num_bad) begin
              ev_kind = K_ERROR;
              ev_err  = (phase_r == PH_CNT) ? E_BAD_COUNT : E_BAD_LEN;
            end
          end else if (q_item.is_lf) begin
            ev_kind = K_ERROR;
            ev_err  = E_BAD_TERM;
          end else begin
            ev_kind = K_ERROR;
            ev_err  = (phase_r == PH_CNT) ? E_BAD_COUNT : E_BAD_LEN;
          end
        end
        PH_CNT_LF, PH_LEN_LF, PH_DCR: begin
          if ((phase_r == PH_DCR) ? !q_item.is_cr : !q_item.is_lf) begin
            ev_kind = K_ERROR;
            ev_err  = E_BAD_TERM;
          end
        end
        PH_DOL: begin
          if (!q_item.is_dollar) begin
            ev_kind = K_ERROR;
            ev_err  = E_BAD_LEN;
          end
        end
        PH_DATA: begin
          ev_kind = K_DATA;
          ev_data = q_item.data;
        end
        PH_DLF: begin
          if (!q_item.is_lf) begin
            ev_kind = K_ERROR;
            ev_err  = E_BAD_TERM;
          end else if (args_dec == 11'd0) begin
            ev_kind = K_CMD_END;
          end else begin
            ev_kind = K_ARG_END;
          end
        end
        default: begin
          ev_kind = K_ERROR;
          ev_err  = E_BAD_TERM;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      args_r  <= '0;
      bytes_r <= '0;
      cur_r   <= '0;
      has_r   <= 1'b0;
      fe_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        args_r  <= args_nxt;
        bytes_r <= bytes_nxt;
        cur_r   <= cur_nxt;
        has_r   <= has_nxt;
        fe_r    <= fe_nxt;
        ov_r    <= 1'b1;
      end else if (out_ready) begin
        ov_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      od_r <= {ev_inl, ev_err, cur_r, ev_data, ev_kind};
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

[hw/rtl/resp_request_parser.sv]
// ----------------------------------------------------------------------------
// resp_request_parser
// Streaming RESP request parser: one event per request byte.
// ----------------------------------------------------------------------------
// Path: each input transaction is registered in a queue entry, then in the
//   parser stage's output register.
// Throughput: 1 byte per cycle while out_tready does not stall the result.
// Reset: synchronous active-low rst_n; parser idle, queue empty, registers
//   at max_args 64, max_arg_len 65536, delimiter 32.
module resp_request_parser import rrp_pkg::*; #(
  parameter int unsigned ARG_LIMIT = ArgLimitDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [2:0] kind, [10:3] data_byte, [20:11] arg_index,
                                  // [23:21] error_code, [24] is_inline, [31:25] zero
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [10:0] max_args_r;
  logic [20:0] max_arg_len_r;
  logic [7:0]  delim_r;
  logic        q_valid, q_pop;
  item_t       q_item;
  logic [24:0] res;

  // config writes are always taken; indexes beyond the list are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_args_r    <= MaxArgsReset;
      max_arg_len_r <= MaxArgLenReset;
      delim_r       <= DelimReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_ARGS:    max_args_r    <= cfg_data[10:0];
        CFG_MAX_ARG_LEN: max_arg_len_r <= cfg_data[20:0];
        CFG_DELIM:       delim_r       <= cfg_data[7:0];
        default:         ;
      endcase
    end
  end

  // front: byte classification and a 2-deep queue
  rrp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .delim    (delim_r),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back: parser state machine with registered result
  rrp_back #(
    .ARG_LIMIT (ARG_LIMIT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_args    (max_args_r),
    .max_arg_len (max_arg_len_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (res)
  );

  assign out_tdata = {7'd0, res};

endmodule
